FILE: hw/rtl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;
  localparam logic [2:0] OP_NEG = 3'd5;
  localparam logic [2:0] OP_NRM = 3'd6;
  localparam logic [2:0] OP_NOP = 3'd7;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef struct packed {
    logic load;
    logic mul_start;
    logic mul_sel_b;
    logic sum_load;
    logic gcd_start;
    logic gcd_step;
    logic div_start;
    logic div_step;
    logic finish;
  } rau_cmd_t;

  typedef struct packed {
    logic trivial;
    logic gcd_done;
    logic div_done;
  } rau_stat_t;

endpackage

FILE: hw/rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit.
// An item passes through these steps: the exact products are formed, then a binary gcd of one
// bit a step runs on the 66-bit numerator and denominator, then two 66-step shift-subtract
// divisions by the gcd; zero, compare and error results skip the gcd and division. A result
// is held until taken, and the next item is taken once the result register is free.
module rational_arithmetic_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [135:0]  s_tdata,  // op, a_num, a_den, b_num, b_den, zero fill
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [71:0]   m_tdata   // res_num, res_den, less, equal, status, zero fill
);

  rau_pkg::rau_cmd_t  cmd;
  rau_pkg::rau_stat_t stat;
  logic               busy, in_fire, out_fire;
  logic [31:0]        res_num;
  logic [30:0]        res_den;
  logic               less, equal;
  logic [1:0]         status;

  assign s_tready = !busy;
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  rau_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_fire(out_fire),
    .busy(busy), .out_valid(m_tvalid), .cmd(cmd), .stat(stat)
  );

  rau_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .op(s_tdata[2:0]), .a_num(s_tdata[34:3]), .a_den(s_tdata[66:35]),
    .b_num(s_tdata[98:67]), .b_den(s_tdata[129:99]),
    .res_num(res_num), .res_den(res_den), .less(less), .equal(equal), .status(status)
  );

  assign m_tdata = {5'd0, status, equal, less, res_den, res_num};

endmodule

FILE: hw/rtl/rau_datapath.sv
// Datapath: operand prep, products, binary gcd and shift-subtract division.
module rau_datapath #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  rau_pkg::rau_cmd_t       cmd,
  output rau_pkg::rau_stat_t      stat,
  input  logic [2:0]              op,
  input  logic [31:0]             a_num,
  input  logic [31:0]             a_den,
  input  logic [31:0]             b_num,
  input  logic [30:0]             b_den,
  output logic [31:0]             res_num,
  output logic [30:0]             res_den,
  output logic                    less,
  output logic                    equal,
  output logic [1:0]              status
);

  logic [2:0]         opr;
  logic signed [32:0] an, ad, bn, bd;
  logic signed [65:0] p, q;
  logic signed [66:0] n;
  logic signed [66:0] d;
  logic               neg;
  logic [65:0]        nm, dm;
  logic [65:0]        gx, gy;
  logic [6:0]         gk;
  logic [65:0]        rem, quo, dvsr;
  logic [6:0]         dcnt;
  logic               second;
  logic [65:0]        qn;
  logic [65:0]        maxv;

  assign maxv = (66'd1 << (VALUE_WIDTH - 1)) - 66'd1;

  logic zero_den;
  assign zero_den = (ad == 33'sd0) || ((bd == 33'sd0) && (opr != rau_pkg::OP_NEG)
                    && (opr != rau_pkg::OP_NRM)) || ((opr == rau_pkg::OP_DIV) && (bn == 33'sd0));
  assign stat.trivial  = zero_den || (opr == rau_pkg::OP_CMP) || (opr == rau_pkg::OP_NOP)
                         || (n == 67'sd0);
  assign stat.gcd_done = (gx == 66'd0);
  assign stat.div_done = (dcnt == 7'd0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opr <= op;
      an  <= 33'(signed'(a_num));
      ad  <= 33'(signed'(a_den));
      bn  <= 33'(signed'(b_num));
      bd  <= {2'b00, b_den};
    end
    if (cmd.mul_start) begin
      if (ad < 0 && opr == rau_pkg::OP_CMP) begin
        an <= -an;
        ad <= -ad;
      end
    end
    if (cmd.mul_sel_b) begin
      case (opr)
        rau_pkg::OP_MUL: begin
          p <= 66'(an * bn);
          q <= 66'(ad * bd);
        end
        rau_pkg::OP_DIV: begin
          p <= 66'(an * bd);
          q <= 66'(ad * bn);
        end
        rau_pkg::OP_NEG: begin
          p <= 66'(-an);
          q <= 66'(ad);
        end
        rau_pkg::OP_NRM: begin
          p <= 66'(an);
          q <= 66'(ad);
        end
        default: begin
          p <= 66'(an * bd);
          q <= 66'(bn * ad);
        end
      endcase
    end
    if (cmd.sum_load) begin
      case (opr)
        rau_pkg::OP_ADD: begin
          n <= 67'(p) + 67'(q);
          d <= 67'(ad * bd);
        end
        rau_pkg::OP_SUB: begin
          n <= 67'(p) - 67'(q);
          d <= 67'(ad * bd);
        end
        rau_pkg::OP_CMP: begin
          n <= 67'(p) - 67'(q);
          d <= 67'sd1;
        end
        default: begin
          n <= 67'(p);
          d <= 67'(q);
        end
      endcase
    end
    if (cmd.gcd_start) begin
      neg <= (n < 0) ^ (d < 0);
      nm  <= 66'((n < 0) ? -n : n);
      dm  <= 66'((d < 0) ? -d : d);
      gx  <= 66'((n < 0) ? -n : n);
      gy  <= 66'((d < 0) ? -d : d);
      gk  <= 7'd0;
    end else if (cmd.gcd_step) begin
      if (!gx[0] && !gy[0]) begin
        gx <= gx >> 1;
        gy <= gy >> 1;
        gk <= gk + 7'd1;
      end else if (!gx[0]) begin
        gx <= gx >> 1;
      end else if (!gy[0]) begin
        gy <= gy >> 1;
      end else if (gx >= gy) begin
        gx <= (gx - gy) >> 1;
      end else begin
        gy <= (gy - gx) >> 1;
      end
    end
    if (cmd.div_start) begin
      if (!second) begin
        rem  <= 66'd0;
        quo  <= nm;
        dvsr <= gy << gk;
        dcnt <= 7'd66;
      end else begin
        rem  <= 66'd0;
        quo  <= dm;
        dcnt <= 7'd66;
      end
    end else if (cmd.div_step && dcnt != 7'd0) begin
      if ({rem[64:0], quo[65]} >= dvsr) begin
        rem <= {rem[64:0], quo[65]} - dvsr;
        quo <= {quo[64:0], 1'b1};
      end else begin
        rem <= {rem[64:0], quo[65]};
        quo <= {quo[64:0], 1'b0};
      end
      dcnt <= dcnt - 7'd1;
    end
    if (cmd.div_step && dcnt == 7'd0 && !second) begin
      qn <= quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      second <= 1'b0;
    end else if (cmd.div_step && dcnt == 7'd0) begin
      second <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_num <= 32'd0;
      res_den <= 31'd1;
      less    <= 1'b0;
      equal   <= 1'b0;
      status  <= rau_pkg::ST_OK;
      if (zero_den && opr != rau_pkg::OP_NOP) begin
        status <= rau_pkg::ST_ZERO;
      end else if (opr == rau_pkg::OP_CMP) begin
        less  <= n < 0;
        equal <= n == 0;
      end else if (!stat.trivial) begin
        if ((neg ? (qn > maxv + 66'd1) : (qn > maxv)) || (quo > maxv)) begin
          status <= rau_pkg::ST_OVF;
        end else begin
          res_num <= 32'(neg ? -qn : qn);
          res_den <= 31'(quo);
        end
      end
    end
  end

endmodule

FILE: hw/rtl/rau_ctrl.sv
// Controller state machine sequencing one item through the datapath.
module rau_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic               out_fire,
  output logic               busy,
  output logic               out_valid,
  output rau_pkg::rau_cmd_t  cmd,
  input  rau_pkg::rau_stat_t stat
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_PREP = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_SUM  = 9'b000001000,
    S_GINI = 9'b000010000,
    S_GCD  = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_DIV2 = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   pend;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: if (in_fire) begin
        cmd.load = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        cmd.mul_start = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_sel_b = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum_load = 1'b1;
        state_next = S_GINI;
      end
      S_GINI: begin
        if (stat.trivial) begin
          cmd.finish = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.gcd_start = 1'b1;
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        if (stat.gcd_done) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = S_DIV2;
        end
      end
      S_DIV2: begin
        cmd.div_start = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!pend) begin
          cmd.div_step = 1'b1;
          if (stat.div_done) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        end else if (out_fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_GINI && stat.trivial) begin
        pend <= 1'b1;
      end else if (state == S_OUT && out_fire) begin
        pend <= 1'b0;
      end
    end
  end

  logic vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (cmd.finish) begin
      vld <= 1'b1;
    end else if (out_fire) begin
      vld <= 1'b0;
    end
  end

  assign out_valid = vld;
  assign busy = (state != S_IDLE) || (vld && !out_fire);

endmodule
